@@ hdl/osl_pkg.sv @@
package osl_pkg;

    localparam logic [15:0] HDR_CODE  = 16'hDECA;
    localparam logic [15:0] HDR_DATA  = 16'hDADA;
    localparam logic [15:0] HDR_SYM   = 16'hB7C3;
    localparam logic [15:0] HDR_FNAME = 16'h7EF1;
    localparam logic [15:0] HDR_LINE  = 16'h5E71;
    localparam logic [15:0] DATA_LO   = 16'h2000;
    localparam logic [15:0] DATA_HI   = 16'h7FFF;
    localparam logic [15:0] LINE_WORDS = 16'd3;

    // result kinds
    localparam logic RK_WRITE  = 1'b0;
    localparam logic RK_FINISH = 1'b1;

    // load status codes
    localparam logic [1:0] ST_OK           = 2'd0;
    localparam logic [1:0] ST_CODE_IN_DATA = 2'd1;
    localparam logic [1:0] ST_DATA_IN_CODE = 2'd2;
    localparam logic [1:0] ST_TRUNCATED    = 2'd3;

    typedef struct packed {
        logic        valid;
        logic        kind;
        logic [15:0] address;
        logic [15:0] data;
        logic [1:0]  status;
    } t_result;

endpackage

@@ hdl/object_file_section_loader_top.sv @@
// Object file section loader.
// Input channel (i_in_valid / o_in_ready) carries one byte of the file per
// request, with i_end_of_stream high on the last byte. Output channel
// (o_out_valid / i_out_ready) carries one result per request: a memory write
// (o_result_kind = 0) for each code or data word, or a finish result
// (o_result_kind = 1) with o_load_status for the byte flagged end of stream;
// a finish result also carries a write if that final byte completed a word.
// Most bytes produce no result.
// A result is registered and appears on the output in the cycle after its byte is taken.
// Throughput: one byte per cycle while o_in_ready is high; the parser
// updates its state in the cycle the byte is taken and the single output
// register holds the result. o_in_ready is high whenever the output register
// is empty or being drained, so a stalled receiver stops input only while a
// result waits in it. Reset (synchronous, active low) empties the output
// register and returns the parser to awaiting a section header with no error
// held. A byte flagged end of stream does the same to the parser once parsed.
module object_file_section_loader_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_end_of_stream,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_result_kind,
    output logic [15:0] o_write_address,
    output logic [15:0] o_write_data,
    output logic [1:0]  o_load_status
);

    osl_pkg::t_result result;
    logic             take;
    logic             r_out_valid;
    logic             r_kind;
    logic [15:0]      r_address;
    logic [15:0]      r_data;
    logic [1:0]       r_status;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign take       = i_in_valid && o_in_ready;

    osl_parser u_parser (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_take          (take),
        .i_data_byte     (i_data_byte),
        .i_end_of_stream (i_end_of_stream),
        .o_result        (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (take) begin
            r_out_valid <= result.valid;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_kind    <= result.kind;
            r_address <= result.address;
            r_data    <= result.data;
            r_status  <= result.status;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_result_kind   = r_kind;
    assign o_write_address = r_address;
    assign o_write_data    = r_data;
    assign o_load_status   = r_status;

endmodule

@@ hdl/osl_parser.sv @@
module osl_parser (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_take,
    input  logic [7:0]        i_data_byte,
    input  logic              i_end_of_stream,
    output osl_pkg::t_result  o_result
);

    typedef enum logic [2:0] {
        PH_HEADER = 3'd0,
        PH_ADDR   = 3'd1,
        PH_COUNT  = 3'd2,
        PH_WORDS  = 3'd3,
        PH_BYTES  = 3'd4,
        PH_LINE   = 3'd5
    } t_phase;

    typedef enum logic [2:0] {
        K_NONE  = 3'd0,
        K_CODE  = 3'd1,
        K_DATA  = 3'd2,
        K_SYM   = 3'd3,
        K_FNAME = 3'd4,
        K_LINE  = 3'd5
    } t_kind;

    t_phase      r_phase, n_phase;
    t_kind       r_kind, n_kind;
    logic [7:0]  r_hold, n_hold;
    logic        r_half, n_half;
    logic [15:0] r_addr, n_addr;
    logic [15:0] r_items, n_items;
    logic [1:0]  r_err, n_err;
    logic        r_sink, n_sink;

    logic [15:0] word;
    logic [15:0] items_dec;
    logic [15:0] addr_inc;
    logic        wr;

    function automatic logic [1:0] region_err(input t_kind kind, input logic [15:0] addr);
        logic in_data;
        in_data = (addr >= osl_pkg::DATA_LO) && (addr <= osl_pkg::DATA_HI);
        if (kind == K_CODE && in_data) begin
            return osl_pkg::ST_CODE_IN_DATA;
        end else if (kind == K_DATA && !in_data) begin
            return osl_pkg::ST_DATA_IN_CODE;
        end
        return osl_pkg::ST_OK;
    endfunction

    assign word      = {r_hold, i_data_byte};
    assign items_dec = r_items - 16'd1;
    assign addr_inc  = r_addr + 16'd1;

    always_comb begin
        n_phase  = r_phase;
        n_kind   = r_kind;
        n_hold   = r_hold;
        n_half   = r_half;
        n_addr   = r_addr;
        n_items  = r_items;
        n_err    = r_err;
        n_sink   = r_sink;
        wr       = 1'b0;
        o_result = '0;

        if (!r_sink) begin
            if (r_phase == PH_BYTES) begin
                n_items = items_dec;
                if (items_dec == 16'd0) begin
                    n_phase = PH_HEADER;
                    n_kind  = K_NONE;
                end
            end else if (!r_half) begin
                n_hold = i_data_byte;
                n_half = 1'b1;
            end else begin
                n_half = 1'b0;
                case (r_phase)
                    PH_ADDR: begin
                        n_addr  = word;
                        n_phase = PH_COUNT;
                    end
                    PH_COUNT: begin
                        n_items = word;
                        if (word == 16'd0) begin
                            n_phase = PH_HEADER;
                            n_kind  = K_NONE;
                        end else if (r_kind == K_CODE || r_kind == K_DATA) begin
                            n_phase = PH_WORDS;
                            if (region_err(r_kind, r_addr) != osl_pkg::ST_OK) begin
                                n_err  = region_err(r_kind, r_addr);
                                n_sink = 1'b1;
                            end
                        end else begin
                            n_phase = PH_BYTES;
                        end
                    end
                    PH_WORDS: begin
                        wr      = 1'b1;
                        n_addr  = addr_inc;
                        n_items = items_dec;
                        if (items_dec == 16'd0) begin
                            n_phase = PH_HEADER;
                            n_kind  = K_NONE;
                        end else if (region_err(r_kind, addr_inc) != osl_pkg::ST_OK) begin
                            n_err  = region_err(r_kind, addr_inc);
                            n_sink = 1'b1;
                        end
                    end
                    PH_LINE: begin
                        n_items = items_dec;
                        if (items_dec == 16'd0) begin
                            n_phase = PH_HEADER;
                            n_kind  = K_NONE;
                        end
                    end
                    default: begin
                        n_phase = PH_HEADER;
                        n_kind  = K_NONE;
                        if (word == osl_pkg::HDR_CODE) begin
                            n_kind  = K_CODE;
                            n_phase = PH_ADDR;
                        end else if (word == osl_pkg::HDR_DATA) begin
                            n_kind  = K_DATA;
                            n_phase = PH_ADDR;
                        end else if (word == osl_pkg::HDR_SYM) begin
                            n_kind  = K_SYM;
                            n_phase = PH_ADDR;
                        end else if (word == osl_pkg::HDR_FNAME) begin
                            n_kind  = K_FNAME;
                            n_phase = PH_COUNT;
                        end else if (word == osl_pkg::HDR_LINE) begin
                            n_kind  = K_LINE;
                            n_phase = PH_LINE;
                            n_items = osl_pkg::LINE_WORDS;
                        end
                    end
                endcase
            end
        end

        if (wr) begin
            o_result.valid   = 1'b1;
            o_result.kind    = osl_pkg::RK_WRITE;
            o_result.address = r_addr;
            o_result.data    = word;
        end

        if (i_end_of_stream) begin
            o_result.valid = 1'b1;
            o_result.kind  = osl_pkg::RK_FINISH;
            if (n_sink) begin
                o_result.status = n_err;
            end else if (n_phase != PH_HEADER || n_half) begin
                o_result.status = osl_pkg::ST_TRUNCATED;
            end else begin
                o_result.status = osl_pkg::ST_OK;
            end
            // back to the idle parse state for the next file
            n_phase = PH_HEADER;
            n_kind  = K_NONE;
            n_hold  = '0;
            n_half  = 1'b0;
            n_addr  = '0;
            n_items = '0;
            n_err   = osl_pkg::ST_OK;
            n_sink  = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HEADER;
            r_kind  <= K_NONE;
            r_hold  <= '0;
            r_half  <= 1'b0;
            r_addr  <= '0;
            r_items <= '0;
            r_err   <= osl_pkg::ST_OK;
            r_sink  <= 1'b0;
        end else if (i_take) begin
            r_phase <= n_phase;
            r_kind  <= n_kind;
            r_hold  <= n_hold;
            r_half  <= n_half;
            r_addr  <= n_addr;
            r_items <= n_items;
            r_err   <= n_err;
            r_sink  <= n_sink;
        end
    end

endmodule

@@ hdl/osl_checker.sv @@
module osl_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_in_ready,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic        o_result_kind,
    input logic [15:0] o_write_address,
    input logic [1:0]  o_load_status
);

    // a held result stays until taken, with its payload unchanged
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_result_kind)
            && $stable(o_write_address) && $stable(o_load_status))
        else $error("result dropped or changed while stalled");

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input stalled with empty output register");

    a_write_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_result_kind == osl_pkg::RK_WRITE |-> o_load_status == osl_pkg::ST_OK)
        else $error("write result carries a nonzero status");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid right after reset");

endmodule

bind object_file_section_loader_top osl_checker u_osl_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_in_ready      (o_in_ready),
    .o_out_valid     (o_out_valid),
    .i_out_ready     (i_out_ready),
    .o_result_kind   (o_result_kind),
    .o_write_address (o_write_address),
    .o_load_status   (o_load_status)
);

@@ bench/tb_object_file_section_loader_top.sv @@
module tb_object_file_section_loader_top;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT  = 2000;
    localparam int HOLD_CYCLES  = 400;
    localparam int RANDOM_BYTES = 650;

    typedef enum logic [3:0] {
        PH_HEADER, PH_ADDR, PH_COUNT, PH_WORDS, PH_BYTES, PH_LINE
    } t_phase;

    typedef enum logic [2:0] {
        SK_NONE, SK_CODE, SK_DATA, SK_SYM, SK_FNAME, SK_LINE
    } t_section;

    typedef struct packed {
        logic        kind;
        logic [15:0] addr;
        logic [15:0] data;
        logic [1:0]  status;
    } t_load_result;

    logic        i_clk;
    logic        i_rst_n         = 1'b0;
    logic        i_in_valid      = 1'b0;
    logic        o_in_ready;
    logic [7:0]  i_data_byte     = 8'h00;
    logic        i_end_of_stream = 1'b0;
    logic        o_out_valid;
    logic        i_out_ready     = 1'b0;
    logic        o_result_kind;
    logic [15:0] o_write_address;
    logic [15:0] o_write_data;
    logic [1:0]  o_load_status;

    object_file_section_loader_top dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_data_byte     (i_data_byte),
        .i_end_of_stream (i_end_of_stream),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_result_kind   (o_result_kind),
        .o_write_address (o_write_address),
        .o_write_data    (o_write_data),
        .o_load_status   (o_load_status)
    );

    // {end_of_stream, byte}
    logic [8:0]   bytes_to_send[$];
    t_load_result results_due[$];

    int n_queued = 0;
    int n_taken = 0;
    int n_files = 0;
    int n_errors = 0;
    int n_writes_seen = 0;
    int n_finish_seen = 0;
    int status_seen[4] = '{0, 0, 0, 0};
    int stall_cycles = 0;
    int hold_left = 0;
    bit hold_done = 1'b0;
    bit random_phase = 1'b0;

    // loader shadow state
    t_phase      ld_phase;
    t_section    ld_kind;
    logic [7:0]  ld_hold;
    logic        ld_half;
    logic [15:0] ld_addr;
    logic [15:0] ld_left;
    logic [1:0]  ld_err;
    logic        ld_sink;
    logic        wr_hit;
    logic [15:0] wr_addr;
    logic [15:0] wr_data;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic void reset_loader();
        ld_phase = PH_HEADER;
        ld_kind  = SK_NONE;
        ld_hold  = 8'h00;
        ld_half  = 1'b0;
        ld_addr  = 16'h0000;
        ld_left  = 16'h0000;
        ld_err   = osl_pkg::ST_OK;
        ld_sink  = 1'b0;
    endfunction

    function automatic void close_section();
        ld_phase = PH_HEADER;
        ld_kind  = SK_NONE;
    endfunction

    function automatic void check_target();
        logic in_data;
        in_data = (ld_addr >= osl_pkg::DATA_LO) && (ld_addr <= osl_pkg::DATA_HI);
        if (ld_kind == SK_CODE && in_data) begin
            ld_err  = osl_pkg::ST_CODE_IN_DATA;
            ld_sink = 1'b1;
        end else if (ld_kind == SK_DATA && !in_data) begin
            ld_err  = osl_pkg::ST_DATA_IN_CODE;
            ld_sink = 1'b1;
        end
    endfunction

    function automatic void take_loader_word(input logic [15:0] w);
        case (ld_phase)
            PH_ADDR: begin
                ld_addr  = w;
                ld_phase = PH_COUNT;
            end
            PH_COUNT: begin
                ld_left = w;
                if (w == 16'h0000) begin
                    close_section();
                end else if (ld_kind == SK_CODE || ld_kind == SK_DATA) begin
                    ld_phase = PH_WORDS;
                    check_target();
                end else begin
                    ld_phase = PH_BYTES;
                end
            end
            PH_WORDS: begin
                wr_hit  = 1'b1;
                wr_addr = ld_addr;
                wr_data = w;
                ld_addr = ld_addr + 16'd1;
                ld_left = ld_left - 16'd1;
                if (ld_left == 16'h0000) close_section();
                else check_target();
            end
            PH_LINE: begin
                ld_left = ld_left - 16'd1;
                if (ld_left == 16'h0000) close_section();
            end
            default: begin
                close_section();
                if (w == osl_pkg::HDR_CODE) begin
                    ld_kind  = SK_CODE;
                    ld_phase = PH_ADDR;
                end else if (w == osl_pkg::HDR_DATA) begin
                    ld_kind  = SK_DATA;
                    ld_phase = PH_ADDR;
                end else if (w == osl_pkg::HDR_SYM) begin
                    ld_kind  = SK_SYM;
                    ld_phase = PH_ADDR;
                end else if (w == osl_pkg::HDR_FNAME) begin
                    ld_kind  = SK_FNAME;
                    ld_phase = PH_COUNT;
                end else if (w == osl_pkg::HDR_LINE) begin
                    ld_kind  = SK_LINE;
                    ld_phase = PH_LINE;
                    ld_left  = osl_pkg::LINE_WORDS;
                end
            end
        endcase
    endfunction

    function automatic void parse_file_byte(input logic [7:0] b, input logic eos);
        t_load_result due;
        wr_hit  = 1'b0;
        wr_addr = 16'h0000;
        wr_data = 16'h0000;
        if (!ld_sink) begin
            if (ld_phase == PH_BYTES) begin
                ld_left = ld_left - 16'd1;
                if (ld_left == 16'h0000) close_section();
            end else if (!ld_half) begin
                ld_hold = b;
                ld_half = 1'b1;
            end else begin
                ld_half = 1'b0;
                take_loader_word({ld_hold, b});
            end
        end
        if (eos) begin
            due.kind = osl_pkg::RK_FINISH;
            due.addr = wr_hit ? wr_addr : 16'h0000;
            due.data = wr_hit ? wr_data : 16'h0000;
            if (ld_sink) due.status = ld_err;
            else if (ld_phase != PH_HEADER || ld_half) due.status = osl_pkg::ST_TRUNCATED;
            else due.status = osl_pkg::ST_OK;
            results_due.push_back(due);
            reset_loader();
        end else if (wr_hit) begin
            due.kind   = osl_pkg::RK_WRITE;
            due.addr   = wr_addr;
            due.data   = wr_data;
            due.status = osl_pkg::ST_OK;
            results_due.push_back(due);
        end
    endfunction

    task automatic note_mismatch(input string msg);
        if (n_errors < 40) $display("tb: mismatch at %0t: %s", $realtime, msg);
        n_errors++;
    endtask

    task automatic check_result();
        t_load_result want;
        if (results_due.size() == 0) begin
            note_mismatch($sformatf("result with none due: kind %0d addr %h data %h status %0d",
                o_result_kind, o_write_address, o_write_data, o_load_status));
            return;
        end
        want = results_due.pop_front();
        if (o_result_kind !== want.kind)
            note_mismatch($sformatf("kind %b, want %b", o_result_kind, want.kind));
        if (o_write_address !== want.addr)
            note_mismatch($sformatf("address %h, want %h", o_write_address, want.addr));
        if (o_write_data !== want.data)
            note_mismatch($sformatf("data %h, want %h", o_write_data, want.data));
        if (o_load_status !== want.status)
            note_mismatch($sformatf("status %0d, want %0d", o_load_status, want.status));
        if (want.kind == osl_pkg::RK_FINISH) begin
            n_finish_seen++;
            status_seen[want.status]++;
        end else begin
            n_writes_seen++;
        end
    endtask

    function automatic bit quiet_stretch();
        return n_taken >= 350 && n_taken < 470;
    endfunction

    // ---- stimulus building ----

    function automatic void put_byte(input logic [7:0] b);
        bytes_to_send.push_back({1'b0, b});
        n_queued++;
    endfunction

    function automatic void put_word(input logic [15:0] w);
        put_byte(w[15:8]);
        put_byte(w[7:0]);
    endfunction

    function automatic void close_file(input int start);
        logic [8:0] tail;
        if (n_queued == start) put_byte(8'($urandom));
        tail = bytes_to_send.pop_back();
        bytes_to_send.push_back({1'b1, tail[7:0]});
        n_files++;
    endfunction

    function automatic logic [15:0] pick_base(input bit is_data);
        int r;
        r = $urandom_range(0, 99);
        if (r >= 80) return 16'($urandom);
        if (!is_data) begin
            if (r < 60) begin
                if ($urandom_range(0, 1) == 0) return 16'($urandom_range(0, 16'h1FFF));
                return 16'($urandom_range(16'h8000, 16'hFFFF));
            end
            case ($urandom_range(0, 3))
                0:       return osl_pkg::DATA_LO - 16'($urandom_range(1, 4));
                1:       return 16'hFFFF - 16'($urandom_range(0, 3));
                2:       return 16'h8000;
                default: return 16'h0000;
            endcase
        end
        if (r < 60) return 16'($urandom_range(osl_pkg::DATA_LO, osl_pkg::DATA_HI));
        case ($urandom_range(0, 3))
            0:       return 16'h8000 - 16'($urandom_range(1, 4));
            1:       return osl_pkg::DATA_LO;
            2:       return osl_pkg::DATA_HI;
            default: return 16'h1FFF;
        endcase
    endfunction

    // return 1 when the section is left open on purpose
    function automatic bit put_load_section(input bit is_data);
        logic [15:0] count;
        int r, n;
        put_word(is_data ? osl_pkg::HDR_DATA : osl_pkg::HDR_CODE);
        put_word(pick_base(is_data));
        r = $urandom_range(0, 99);
        if (r < 8) count = 16'h0000;
        else if (r < 12) count = 16'hFFFF;
        else count = 16'($urandom_range(1, 6));
        put_word(count);
        n = (count == 16'hFFFF) ? $urandom_range(1, 6) : int'(count);
        for (int k = 0; k < n; k++) put_word(16'($urandom));
        return count == 16'hFFFF;
    endfunction

    function automatic void put_skip_section(input bit with_addr);
        int n;
        put_word(with_addr ? osl_pkg::HDR_SYM : osl_pkg::HDR_FNAME);
        if (with_addr) put_word(16'($urandom));
        n = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 5);
        put_word(16'(n));
        for (int k = 0; k < n; k++) put_byte(8'($urandom));
    endfunction

    function automatic void put_odd_header();
        logic [15:0] w;
        do w = 16'($urandom);
        while (w == osl_pkg::HDR_CODE || w == osl_pkg::HDR_DATA || w == osl_pkg::HDR_SYM
               || w == osl_pkg::HDR_FNAME || w == osl_pkg::HDR_LINE);
        put_word(w);
    endfunction

    function automatic void put_file();
        int start, pick, cut;
        bit left_open;
        start = n_queued;
        left_open = 1'b0;
        for (int s = $urandom_range(1, 4); s > 0 && !left_open; s--) begin
            pick = $urandom_range(0, 99);
            if (pick < 35) left_open = put_load_section(1'b0);
            else if (pick < 60) left_open = put_load_section(1'b1);
            else if (pick < 70) put_skip_section(1'b1);
            else if (pick < 78) put_skip_section(1'b0);
            else if (pick < 86) begin
                put_word(osl_pkg::HDR_LINE);
                for (int k = 0; k < 3; k++) put_word(16'($urandom));
            end else if (pick < 93) put_odd_header();
            else for (int k = $urandom_range(1, 3); k > 0; k--) put_byte(8'($urandom));
        end
        // cut the file short now and then
        if ($urandom_range(0, 99) < 12) begin
            cut = $urandom_range(1, 3);
            while (cut > 0 && n_queued > start) begin
                void'(bytes_to_send.pop_back());
                n_queued--;
                cut--;
            end
        end
        close_file(start);
    endfunction

    // ---- driver, receiver, monitor, watchdog ----

    always @(posedge i_clk) begin
        logic [8:0] req;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || o_in_ready) begin
            if (bytes_to_send.size() > 0
                && (quiet_stretch() || $urandom_range(0, 99) >= 10)) begin
                req = bytes_to_send.pop_front();
                i_in_valid      <= 1'b1;
                i_data_byte     <= req[7:0];
                i_end_of_stream <= req[8];
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            i_out_ready <= 1'b0;
        end else if (!hold_done && random_phase && n_taken >= 150) begin
            // hold off long enough for the input side to back up
            hold_done <= 1'b1;
            hold_left <= HOLD_CYCLES;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= quiet_stretch() || $urandom_range(0, 99) >= 10;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            reset_loader();
        end else begin
            if (o_out_valid && i_out_ready) check_result();
            if (i_in_valid && o_in_ready) begin
                parse_file_byte(i_data_byte, i_end_of_stream);
                n_taken <= n_taken + 1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("tb: no request moved for %0d cycles", STALL_LIMIT);
            $display("tb: failure");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        int start;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        @(negedge i_clk);
        // wrap past 0xFFFF, last byte completes a word
        start = n_queued;
        put_word(osl_pkg::HDR_CODE);
        put_word(16'hFFFF);
        put_word(16'h0002);
        put_word(16'h1234);
        put_word(16'h00FF);
        close_file(start);
        // data aimed below the data region
        start = n_queued;
        put_word(osl_pkg::HDR_DATA);
        put_word(16'h1FFF);
        put_word(16'h0001);
        put_byte(8'h00);
        close_file(start);
        // code aimed into the data region
        start = n_queued;
        put_word(osl_pkg::HDR_CODE);
        put_word(osl_pkg::DATA_HI);
        put_word(16'h0003);
        put_byte(8'hA5);
        close_file(start);
        // lone byte: half a word
        start = n_queued;
        put_byte(8'hFF);
        close_file(start);

        // pause the sender until the directed results are all in
        while (n_taken != n_queued || results_due.size() != 0) @(negedge i_clk);
        random_phase = 1'b1;
        start = n_queued;
        while (n_queued - start < RANDOM_BYTES) put_file();

        while (n_taken != n_queued || results_due.size() != 0) @(negedge i_clk);
        repeat (20) @(posedge i_clk);
        if (results_due.size() != 0)
            note_mismatch($sformatf("%0d results never arrived", results_due.size()));

        $display("tb: %0d bytes in %0d files, %0d writes and %0d finish results checked",
                 n_taken, n_files, n_writes_seen, n_finish_seen);
        $display("tb: finish status ok %0d, code-in-data %0d, data-in-code %0d, truncated %0d",
                 status_seen[0], status_seen[1], status_seen[2], status_seen[3]);
        if (n_errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

@@ object_file_section_loader_top.f @@
hdl/osl_pkg.sv
hdl/osl_parser.sv
hdl/object_file_section_loader_top.sv
hdl/osl_checker.sv
bench/tb_object_file_section_loader_top.sv
